// File: rtl/hfbc_pkg.sv
// Package for the hash Feistel block cipher: types, widths, SHA-256 constants.
// Used by hfbc_ctrl, hfbc_dp and hash_feistel_block_cipher.
package hfbc_pkg;

	localparam int KeyBitsMax = 256;
	localparam int HeadBits = 144;
	localparam int MsgBlocks = ((HeadBits + KeyBitsMax + 65) + 511) / 512;
	localparam int BlkW = (MsgBlocks > 1) ? $clog2(MsgBlocks) : 1;

	localparam logic [2:0] CfgKey0 = 3'd0;
	localparam logic [2:0] CfgKey1 = 3'd1;
	localparam logic [2:0] CfgKey2 = 3'd2;
	localparam logic [2:0] CfgKey3 = 3'd3;
	localparam logic [2:0] CfgKeyBits = 3'd4;
	localparam logic [2:0] CfgRounds = 3'd5;
	localparam logic [2:0] CfgMode = 3'd6;

	typedef struct packed {
		logic load;
		logic start_hash;
		logic load_block;
		logic step;
		logic add_state;
		logic last_round;
		logic apply_round;
		logic [6:0] rnd;
		logic [BlkW-1:0] blk;
	} cmd_t;

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

endpackage

// File: rtl/hash_feistel_block_cipher.sv
// Top level of the hash Feistel block cipher: config registers and output register.
// Depends on hfbc_pkg, hfbc_ctrl, hfbc_dp.
//
// Usage: write key words, key length, round count and mode through the cfg
// channel (index 0..6) while idle. Send a 256-bit block on s_axis; the result
// comes on m_axis. Each round hashes R||0||round||key with SHA-256 over one
// 512-bit block; the key length is capped at 256 bits, so the message always
// fits one block. A round is a load, 64 compression steps on the single round
// unit and a state add; zero rounds pass the block through unchanged. One item
// at a time: s_axis_tready is high only when idle, so a new block is taken only
// once the previous result is in the output register. The result is held in an
// output register; the block returns to idle as soon as the result is in that
// register, and waits in its final state while the register is still full and
// m_axis_tready is low.
// Reset clears the registers to key 0, 128 key bits, 16 rounds, encrypt mode.
module hash_feistel_block_cipher (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [255:0] s_axis_tdata, // in_word0, in_word1, in_word2, in_word3
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [255:0] m_axis_tdata, // out_word0, out_word1, out_word2, out_word3
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key0_q, key1_q, key2_q, key3_q;
	logic [8:0] key_bits_q;
	logic [6:0] rounds_q;
	logic mode_q;
	logic out_valid_q;
	logic out_free, out_load;
	logic [255:0] out_q, result;
	logic [hfbc_pkg::BlkW:0] nblk;
	hfbc_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			key_bits_q <= 9'd128;
			rounds_q <= 7'd16;
			mode_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					hfbc_pkg::CfgKey0: key0_q <= cfg_data;
					hfbc_pkg::CfgKey1: key1_q <= cfg_data;
					hfbc_pkg::CfgKey2: key2_q <= cfg_data;
					hfbc_pkg::CfgKey3: key3_q <= cfg_data;
					hfbc_pkg::CfgKeyBits: key_bits_q <= cfg_data[8:0];
					hfbc_pkg::CfgRounds: rounds_q <= cfg_data[6:0];
					hfbc_pkg::CfgMode: mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	hfbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_free(out_free), .out_load(out_load),
		.round_count(rounds_q), .encrypt_mode(mode_q), .nblk(nblk), .cmd(cmd)
	);

	hfbc_dp u_dp (
		.clk(clk), .cmd(cmd),
		.in_block({s_axis_tdata[63:0], s_axis_tdata[127:64],
			s_axis_tdata[191:128], s_axis_tdata[255:192]}),
		.key({key0_q, key1_q, key2_q, key3_q}), .key_bits(key_bits_q),
		.nblk(nblk), .result(result)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {out_q[63:0], out_q[127:64], out_q[191:128], out_q[255:192]};

endmodule

// File: rtl/hfbc_ctrl.sv
// Controller of the hash Feistel block cipher: sequences rounds, blocks, steps.
// Depends on hfbc_pkg.
module hfbc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_free,
	output logic out_load,
	input  logic [6:0] round_count,
	input  logic encrypt_mode,
	input  logic [hfbc_pkg::BlkW:0] nblk,
	output hfbc_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_INIT  = 5'b00010,
		S_STEP  = 5'b00100,
		S_ADD   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic [6:0] iter_q;
	logic [6:0] n_q;
	logic mode_q;
	logic [5:0] step_q;
	logic [hfbc_pkg::BlkW-1:0] blk_q;
	logic [hfbc_pkg::BlkW:0] nblk_q;
	logic blk_last;

	assign in_ready = (state_q == S_IDLE);
	assign blk_last = ({1'b0, blk_q} + 1'b1) == nblk_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.rnd = mode_q ? iter_q : (n_q - 7'd1 - iter_q);
		cmd.blk = blk_q;
		cmd.last_round = (iter_q + 7'd1) == n_q;
		cmd.start_hash = (state_q == S_INIT) && (blk_q == '0);
		cmd.load_block = (state_q == S_INIT);
		cmd.step = (state_q == S_STEP);
		cmd.add_state = (state_q == S_ADD);
		cmd.apply_round = (state_q == S_ADD) && blk_last;
		out_load = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			n_q <= '0;
			mode_q <= 1'b1;
			step_q <= '0;
			blk_q <= '0;
			nblk_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q <= round_count;
						mode_q <= encrypt_mode;
						nblk_q <= nblk;
						iter_q <= '0;
						blk_q <= '0;
						state_q <= (round_count == '0) ? S_DONE : S_INIT;
					end
				end
				S_INIT: begin
					step_q <= '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					if (!blk_last) begin
						blk_q <= blk_q + 1'b1;
						state_q <= S_INIT;
					end else if (cmd.last_round) begin
						state_q <= S_DONE;
					end else begin
						blk_q <= '0;
						iter_q <= iter_q + 7'd1;
						state_q <= S_INIT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/hfbc_dp.sv
// Datapath of the hash Feistel block cipher: halves, message build, SHA-256 round.
// Depends on hfbc_pkg.
module hfbc_dp (
	input  logic clk,
	input  hfbc_pkg::cmd_t cmd,
	input  logic [255:0] in_block,
	input  logic [255:0] key,
	input  logic [8:0] key_bits,
	output logic [hfbc_pkg::BlkW:0] nblk,
	output logic [255:0] result
);

	localparam int MsgW = hfbc_pkg::MsgBlocks * 512;

	logic [127:0] l_q, r_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0] t_q;
	logic [8:0] kbits;
	logic [9:0] len;
	logic [MsgW-1:0] msg;
	logic [511:0] blk;
	logic [31:0] s0, s1, t1, t2, wn;

	assign kbits = (key_bits > 9'(hfbc_pkg::KeyBitsMax)) ? 9'(hfbc_pkg::KeyBitsMax) : key_bits;
	assign len = 10'(hfbc_pkg::HeadBits) + {1'b0, kbits};
	assign nblk = (hfbc_pkg::BlkW+1)'((11'(len) + 11'd65 + 11'd511) >> 9);

	// Message big-endian from the top bit: R, zero, round, key, pad, length.
	always_comb begin
		logic [MsgW-1:0] keyf, mask;
		logic [hfbc_pkg::BlkW:0] nb;
		msg = '0;
		msg[MsgW-1 -: 128] = r_q;
		msg[MsgW-137 -: 8] = 8'(cmd.rnd);
		keyf = '0;
		keyf[MsgW-145 -: 256] = key;
		mask = ~({MsgW{1'b1}} >> len);
		msg = msg | (keyf & mask);
		msg[MsgW-1-int'(len)] = 1'b1;
		nb = nblk;
		for (int i = 1; i <= hfbc_pkg::MsgBlocks; i++) begin
			if (int'(nb) == i) begin
				msg[MsgW-i*512 +: 64] = 64'(len);
			end
		end
		blk = msg[MsgW-1-int'(cmd.blk)*512 -: 512];
	end

	function automatic logic [31:0] rr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	assign s0 = rr(w_q[1], 7) ^ rr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rr(w_q[14], 17) ^ rr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = hh_q + (rr(e_q, 6) ^ rr(e_q, 11) ^ rr(e_q, 25)) + ((e_q & f_q) ^ (~e_q & g_q))
		+ hfbc_pkg::sha_k(t_q) + w_q[0];
	assign t2 = (rr(a_q, 2) ^ rr(a_q, 13) ^ rr(a_q, 22)) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q <= in_block[255:128];
			r_q <= in_block[127:0];
		end
		if (cmd.start_hash) begin
			h_q <= '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		end
		if (cmd.load_block) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[511-32*i -: 32];
			end
			if (cmd.start_hash) begin
				{a_q, b_q, c_q, d_q} <= {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a};
				{e_q, f_q, g_q, hh_q} <= {32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			end else begin
				{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
				{e_q, f_q, g_q, hh_q} <= {h_q[4], h_q[5], h_q[6], h_q[7]};
			end
			t_q <= '0;
		end
		if (cmd.step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wn;
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
			t_q <= t_q + 6'd1;
		end
		if (cmd.add_state) begin
			h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
			h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
		end
		if (cmd.apply_round) begin
			if (cmd.last_round) begin
				l_q <= l_q ^ {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q, h_q[3] + d_q};
			end else begin
				l_q <= r_q;
				r_q <= l_q ^ {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q, h_q[3] + d_q};
			end
		end
	end

	assign result = {l_q, r_q};

endmodule
